/* hdl/rle_sprite_palette_decoder_macros.svh */
// Assertion macros for the sprite run decoder.
// Used by the top level; expects clk and arst_n in scope.
`ifndef RLE_SPRITE_PALETTE_DECODER_MACROS_SVH
`define RLE_SPRITE_PALETTE_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RSP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsp: same-cycle check failed");

// next-cycle implication, checked out of reset
`define RSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsp: next-cycle check failed");

`endif

/* hdl/rsp_pkg.sv */
// Shared types, constants and the recolor function of the sprite run decoder.
// No dependencies.
package rsp_pkg;

	localparam int PAL_W     = 24;
	localparam int PAL_DEPTH = 256;
	localparam int IDX_W     = 8;
	localparam int LEN_W     = 7;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// item kind on the byte channel
	localparam logic REQ_ROW_BYTE  = 1'b0;
	localparam logic REQ_PAL_WRITE = 1'b1;

	// configuration register index (paddr[3:2])
	typedef enum logic [1:0] {
		REG_ROW_WIDTH = 2'd0,
		REG_ROW_COUNT = 2'd1,
		REG_PLAYER    = 2'd2
	} reg_idx_t;

	// byte decoder state
	typedef enum logic [2:0] {
		MODE_CTRL = 3'b001,
		MODE_REP  = 3'b010,
		MODE_LIT  = 3'b100
	} mode_t;

	// one run as produced by the byte decoder
	typedef struct packed {
		logic             emit;
		logic [IDX_W-1:0] index;
		logic [LEN_W-1:0] len;
		logic             transp;
		logic             row_done;
		logic             sprite_done;
	} run_t;

	// four shades per player set; set 0 is the base (red) set
	localparam logic [PAL_W-1:0] SHADE_TBL [0:7][0:3] = '{
		'{24'h440400, 24'h5c0400, 24'h7c0000, 24'ha40000},
		'{24'h00044c, 24'h00146c, 24'h002494, 24'h003cc0},
		'{24'h003cc0, 24'h04542c, 24'h14845c, 24'h2cb494},
		'{24'h2c082c, 24'h50104c, 24'h743084, 24'h9848b0},
		'{24'h6e200c, 24'h983810, 24'hc45810, 24'hf08414},
		'{24'h0c0c14, 24'h141420, 24'h1c1c2c, 24'h28283c},
		'{24'h24284c, 24'h545480, 24'h9898b4, 24'he0e0e0},
		'{24'hb47400, 24'hcca010, 24'he4cc28, 24'hfcfc48}
	};

	function automatic logic [PAL_W-1:0] recolor(input logic [PAL_W-1:0] rgb,
	                                             input logic [2:0] set);
		logic [PAL_W-1:0] res;
		res = rgb;
		if (set != 3'd0) begin
			for (int i = 0; i < 4; i++) begin
				if (rgb == SHADE_TBL[0][i]) begin
					res = SHADE_TBL[set][i];
				end
			end
		end
		return res;
	endfunction

endpackage

/* hdl/rsp_in_if.sv */
// Input channel: encoded row bytes and palette writes.
// Depends on rsp_pkg.
interface rsp_in_if;
	import rsp_pkg::*;

	logic             valid;
	logic             ready;
	logic             req_type;
	logic [7:0]       stream_byte;
	logic [IDX_W-1:0] pal_addr;
	logic [PAL_W-1:0] pal_color;

	modport source (output valid, req_type, stream_byte, pal_addr, pal_color, input ready);
	modport sink   (input valid, req_type, stream_byte, pal_addr, pal_color, output ready);
endinterface

/* hdl/rsp_out_if.sv */
// Output channel: decoded color runs.
// Depends on rsp_pkg.
interface rsp_out_if;
	import rsp_pkg::*;

	logic             valid;
	logic             ready;
	logic [PAL_W-1:0] pixel_rgb;
	logic [IDX_W-1:0] pixel_index;
	logic [LEN_W-1:0] run_length;
	logic             is_transparent;
	logic             row_done;
	logic             sprite_done;

	modport source (output valid, pixel_rgb, pixel_index, run_length, is_transparent,
	                row_done, sprite_done, input ready);
	modport sink   (input valid, pixel_rgb, pixel_index, run_length, is_transparent,
	                row_done, sprite_done, output ready);
endinterface

/* hdl/rsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hdl/rsp_decode.sv */
// Byte decoder: control/repeat/literal tracking, pixel and row counters.
// Depends on rsp_pkg.
module rsp_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    stream_byte,
	input  logic [7:0]    row_width,
	input  logic [7:0]    row_count,
	output rsp_pkg::run_t run
);
	import rsp_pkg::*;

	mode_t       mode_q, mode_d;
	logic [5:0]  pend_q, pend_d;
	logic [8:0]  pix_q, pix_d;
	logic [7:0]  rows_q, rows_d;
	logic        check;
	logic [5:0]  pend_dec;
	logic [8:0]  pix_sum;
	logic [8:0]  rows_inc;

	assign pend_dec = pend_q - 6'd1;
	assign rows_inc = {1'b0, rows_q} + 9'd1;

	always_comb begin
		mode_d      = mode_q;
		pend_d      = pend_q;
		pix_d       = pix_q;
		rows_d      = rows_q;
		check       = 1'b0;
		run         = '0;
		run.index   = stream_byte;
		case (mode_q)
			MODE_REP: begin
				mode_d   = MODE_CTRL;
				pend_d   = 6'd0;
				run.emit = (pend_q != 6'd0);
				run.len  = {1'b0, pend_q};
				check    = 1'b1;
			end
			MODE_LIT: begin
				pend_d   = pend_dec;
				if (pend_dec == 6'd0) begin
					mode_d = MODE_CTRL;
				end
				run.emit = 1'b1;
				run.len  = 7'd1;
				check    = (pend_dec == 6'd0);
			end
			default: begin
				mode_d = MODE_CTRL;
				if (stream_byte[6]) begin
					pend_d = stream_byte[5:0];
					mode_d = MODE_REP;
				end else if (stream_byte[7]) begin
					// transparent run of index 0
					run.emit   = (stream_byte[6:0] != 7'd0);
					run.index  = '0;
					run.len    = stream_byte[6:0];
					run.transp = 1'b1;
					check      = 1'b1;
				end else begin
					pend_d = stream_byte[5:0];
					if (stream_byte[5:0] != 6'd0) begin
						mode_d = MODE_LIT;
					end
				end
			end
		endcase

		pix_sum = pix_q + {2'b00, run.len};
		if (run.emit) begin
			pix_d = pix_sum;
			if (check && (pix_sum >= {1'b0, row_width})) begin
				run.row_done = 1'b1;
				pix_d        = 9'd0;
				if (rows_inc >= {1'b0, row_count}) begin
					run.sprite_done = 1'b1;
					rows_d          = 8'd0;
				end else begin
					rows_d = rows_inc[7:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CTRL;
			pend_q <= '0;
			pix_q  <= '0;
			rows_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			pix_q  <= pix_d;
			rows_q <= rows_d;
		end
	end
endmodule

/* hdl/rle_sprite_palette_decoder.sv */
// Top level of the run-length sprite decoder with palette lookup and recolor.
// Depends on rsp_pkg, rsp_in_if, rsp_out_if, rsp_ram, rsp_decode and the macros header.
//
//   port      dir   kind        moves
//   byte_in   in    valid/ready one item: row byte or palette write
//   run_out   out   valid/ready one item: color run with row/sprite flags
//   apb       in    APB r/w     row width, row count, player set
//
// A row byte is decoded and its palette read issued at the edge that accepts
// it; the recolored run is loaded into the output register once stage 2 is free.
// One item per cycle when not stalled; palette writes and runless bytes leave nothing.
// Reset clears decode state, counters, valid flags and registers (width 1,
// count 1, player 0); palette contents are undefined until written.
// Output stall holds both stages; byte_in.ready drops only when both are full.
`include "rle_sprite_palette_decoder_macros.svh"

module rle_sprite_palette_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	rsp_in_if.sink                     byte_in,
	rsp_out_if.source                  run_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rsp_pkg::APB_AW-1:0] paddr,
	input  logic [rsp_pkg::APB_DW-1:0] pwdata,
	output logic [rsp_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import rsp_pkg::*;

	// configuration registers
	logic [7:0] row_width_q;
	logic [7:0] row_count_q;
	logic [2:0] player_q;
	logic       cfg_wr;
	reg_idx_t   cfg_sel;

	// stage 1: decoded run waiting on palette read data
	logic             valid_s1;
	logic [IDX_W-1:0] index_s1;
	logic [LEN_W-1:0] len_s1;
	logic             transp_s1;
	logic             rdone_s1;
	logic             sdone_s1;

	// stage 2: output register
	logic             valid_s2;
	logic [PAL_W-1:0] rgb_s2;
	logic [IDX_W-1:0] index_s2;
	logic [LEN_W-1:0] len_s2;
	logic             transp_s2;
	logic             rdone_s2;
	logic             sdone_s2;

	logic             accept;
	logic             row_acc;
	logic             adv_s1;
	run_t             run;
	logic [PAL_W-1:0] pal_rdata;

	// ---------------- APB config ----------------
	assign pready  = 1'b1;
	assign cfg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= 8'd1;
			row_count_q <= 8'd1;
			player_q    <= 3'd0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_ROW_WIDTH: row_width_q <= pwdata[7:0];
				REG_ROW_COUNT: row_count_q <= pwdata[7:0];
				REG_PLAYER:    player_q    <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_ROW_WIDTH: prdata = {{(APB_DW-8){1'b0}}, row_width_q};
			REG_ROW_COUNT: prdata = {{(APB_DW-8){1'b0}}, row_count_q};
			REG_PLAYER:    prdata = {{(APB_DW-3){1'b0}}, player_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	// stage 1 moves on when stage 2 is empty or draining
	assign adv_s1        = valid_s1 && (!valid_s2 || run_out.ready);
	assign byte_in.ready = !valid_s1 || adv_s1;
	assign accept        = byte_in.valid && byte_in.ready;
	assign row_acc       = accept && (byte_in.req_type == REQ_ROW_BYTE);

	// ---------------- decode ----------------
	rsp_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (row_acc),
		.stream_byte (byte_in.stream_byte),
		.row_width   (row_width_q),
		.row_count   (row_count_q),
		.run         (run)
	);

	// palette: written by palette items, read once per emitted run
	rsp_ram #(
		.WIDTH (PAL_W),
		.DEPTH (PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (accept && (byte_in.req_type == REQ_PAL_WRITE)),
		.waddr (byte_in.pal_addr),
		.wdata (byte_in.pal_color),
		.re    (row_acc && run.emit),
		.raddr (run.index),
		.rdata (pal_rdata)
	);

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= row_acc && run.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (row_acc && run.emit) begin
			index_s1  <= run.index;
			len_s1    <= run.len;
			transp_s1 <= run.transp;
			rdone_s1  <= run.row_done;
			sdone_s1  <= run.sprite_done;
		end
	end

	// ---------------- stage 2 / output ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || run_out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rgb_s2    <= recolor(pal_rdata, player_q);
			index_s2  <= index_s1;
			len_s2    <= len_s1;
			transp_s2 <= transp_s1;
			rdone_s2  <= rdone_s1;
			sdone_s2  <= sdone_s1;
		end
	end

	assign run_out.valid          = valid_s2;
	assign run_out.pixel_rgb      = rgb_s2;
	assign run_out.pixel_index    = index_s2;
	assign run_out.run_length     = len_s2;
	assign run_out.is_transparent = transp_s2;
	assign run_out.row_done       = rdone_s2;
	assign run_out.sprite_done    = sdone_s2;

	// ---------------- checks ----------------
	`RSP_ASSERT_NOW(a_sprite_ends_row, valid_s2 && sdone_s2, rdone_s2)
	`RSP_ASSERT_NOW(a_transp_index0, valid_s2 && transp_s2, index_s2 == '0)
	`RSP_ASSERT_NOW(a_ready_low_full, !byte_in.ready, valid_s1 && valid_s2)
	`RSP_ASSERT_NEXT(a_stall_holds, valid_s1 && valid_s2 && !run_out.ready, valid_s1 && $stable(index_s1))

endmodule
